### src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PEF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define PEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pef_pkg.sv
// types and constants for the protobuf field encoder
`timescale 1ns / 1ps
`default_nettype none
package pef_pkg;

  localparam logic [2:0] KIND_VARINT64 = 3'd0;
  localparam logic [2:0] KIND_INT32    = 3'd1;
  localparam logic [2:0] KIND_BOOL     = 3'd2;
  localparam logic [2:0] KIND_FIXED64  = 3'd3;
  localparam logic [2:0] KIND_LEN      = 3'd4;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd5;

  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LEN     = 3'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [28:0] field_number;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAG,
    ST_BODY
  } state_t;

  typedef enum logic [1:0] {
    BODY_VARINT,
    BODY_FIXED,
    BODY_RAW
  } body_mode_t;

  typedef struct packed {
    logic load;
    logic tag_step;
    logic body_step;
  } dp_cmd_t;

  typedef struct packed {
    logic tag_more;
    logic body_last;
  } dp_stat_t;

endpackage
`default_nettype wire

### src/pef_datapath.sv
// tag and body shift registers that form the output bytes
`timescale 1ns / 1ps
`default_nettype none
module pef_datapath (
  input  wire logic             clk,
  input  wire pef_pkg::in_item_t in_data,
  input  wire pef_pkg::dp_cmd_t  cmd,
  output pef_pkg::dp_stat_t      stat,
  output pef_pkg::out_item_t     out_data
);

  logic [31:0]         tag_r, tag_nxt;
  logic [63:0]         val_r, val_nxt;
  pef_pkg::body_mode_t mode_r, mode_nxt;
  logic [2:0]          cnt_r, cnt_nxt;

  logic [2:0]  wire_type;
  logic [63:0] load_val;
  logic        val_more;
  logic [7:0]  body_byte;
  logic        tag_more;
  logic        body_last;

  always_comb begin
    wire_type = pef_pkg::WIRE_VARINT;
    load_val  = in_data.value;
    mode_nxt  = pef_pkg::BODY_VARINT;
    case (in_data.req_type)
      pef_pkg::KIND_INT32: begin
        load_val = {{32{in_data.value[31]}}, in_data.value[31:0]};
      end
      pef_pkg::KIND_BOOL: begin
        load_val = {63'd0, |in_data.value};
      end
      pef_pkg::KIND_FIXED64: begin
        wire_type = pef_pkg::WIRE_FIXED64;
        mode_nxt  = pef_pkg::BODY_FIXED;
      end
      pef_pkg::KIND_LEN: begin
        wire_type = pef_pkg::WIRE_LEN;
      end
      pef_pkg::KIND_PAYLOAD: begin
        mode_nxt = pef_pkg::BODY_RAW;
      end
      default: begin
        mode_nxt = pef_pkg::BODY_VARINT;
      end
    endcase
  end

  assign val_more = |val_r[63:7];

  always_comb begin
    body_byte = val_r[7:0];
    body_last = 1'b1;
    case (mode_r)
      pef_pkg::BODY_VARINT: begin
        body_byte = {val_more, val_r[6:0]};
        body_last = ~val_more;
      end
      pef_pkg::BODY_FIXED: begin
        body_last = (cnt_r == 3'd7);
      end
      default: begin
        body_last = 1'b1;
      end
    endcase
  end

  assign tag_more = |tag_r[31:7];

  assign stat = '{tag_more: tag_more, body_last: body_last};

  always_comb begin
    tag_nxt = tag_r;
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      tag_nxt = {in_data.field_number, wire_type};
      val_nxt = load_val;
      cnt_nxt = 3'd0;
    end else if (cmd.tag_step) begin
      tag_nxt = {7'd0, tag_r[31:7]};
    end else if (cmd.body_step) begin
      // fixed64 walks whole bytes, varints walk 7-bit groups
      if (mode_r == pef_pkg::BODY_FIXED) begin
        val_nxt = {8'd0, val_r[63:8]};
      end else begin
        val_nxt = {7'd0, val_r[63:7]};
      end
      cnt_nxt = cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    val_r <= val_nxt;
    cnt_r <= cnt_nxt;
    if (cmd.load) begin
      mode_r <= mode_nxt;
    end
  end

  assign out_data.out_byte  = cmd.body_step ? body_byte : {tag_more, tag_r[6:0]};
  assign out_data.last_byte = cmd.body_step & body_last;

endmodule
`default_nettype wire

### src/pef_ctrl.sv
// request sequencer: tag phase then body phase; payload requests go straight to the body phase
`timescale 1ns / 1ps
`default_nettype none
module pef_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [2:0]       req_type,
  input  wire pef_pkg::dp_stat_t stat,
  output pef_pkg::dp_cmd_t       cmd,
  output logic                   busy,
  output logic                   out_valid
);

  pef_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pef_pkg::ST_IDLE: begin
        if (start) begin
          if (req_type == pef_pkg::KIND_PAYLOAD) begin
            state_nxt = pef_pkg::ST_BODY;
          end else if (req_type inside {[pef_pkg::KIND_VARINT64 : pef_pkg::KIND_LEN]}) begin
            state_nxt = pef_pkg::ST_TAG;
          end
        end
      end
      pef_pkg::ST_TAG: begin
        if (!stat.tag_more) begin
          state_nxt = pef_pkg::ST_BODY;
        end
      end
      pef_pkg::ST_BODY: begin
        if (stat.body_last) begin
          state_nxt = pef_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pef_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      pef_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      pef_pkg::ST_TAG: begin
        cmd.tag_step = 1'b1;
        out_valid    = 1'b1;
      end
      pef_pkg::ST_BODY: begin
        cmd.body_step = 1'b1;
        out_valid     = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pef_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### src/protobuf_field_encoder.sv
// protobuf field encoder top level: sequencer plus byte datapath
//
//   port group  dir  handshake            beat
//   in_         in   start & !busy        one field request
//   out_        out  out_valid strobe     one wire byte, last_byte on the final one
//
// one byte per cycle once a request is loaded: tag bytes (1..5, none for payload)
// then body bytes (1..10 varint, 8 fixed64, 1 payload), so 1 to 15 bytes per request;
// the tag and varint values shift out in 7-bit groups, fixed64 in whole bytes.
// reset returns the sequencer to idle; unused request kinds are accepted while idle, no beats.
// the receiver cannot stall; busy stays high through the last beat and drops after it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module protobuf_field_encoder (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire pef_pkg::in_item_t  in_data,
  output logic                   out_valid,
  output pef_pkg::out_item_t      out_data
);

  pef_pkg::dp_cmd_t  cmd;
  pef_pkg::dp_stat_t stat;

  pef_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_data.req_type),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pef_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  `PEF_ASSERT_NOW(a_valid_busy, clk, rst_n, out_valid, busy, "beat outside a request")
  `PEF_ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_data.last_byte, !busy,
    "still busy after last beat")
  `PEF_ASSERT_NEXT(a_payload_one, clk, rst_n,
    start && !busy && in_data.req_type == pef_pkg::KIND_PAYLOAD,
    out_valid && out_data.last_byte, "payload byte not a single last beat")
  `PEF_ASSERT_NEXT(a_unused_kind, clk, rst_n,
    start && !busy && (in_data.req_type > pef_pkg::KIND_PAYLOAD),
    !busy && !out_valid, "unused kind produced beats")

endmodule
`default_nettype wire

### tb/protobuf_field_encoder_tb.sv
// self-checking testbench for the protobuf field encoder
`timescale 1ns / 1ps
`default_nettype none
module protobuf_field_encoder_tb;

  // request kinds the block must ignore
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam int RANDOM_REQUESTS = 450;
  localparam int STALL_LIMIT     = 500;
  localparam int DRAIN_CYCLES    = 24;

  class wire_byte_board;
    pef_pkg::out_item_t expected_bytes[$];
    int                 mismatches;
    int                 beats_checked;

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void push_byte(ref pef_pkg::out_item_t seq[$], input logic [7:0] b);
      pef_pkg::out_item_t item;
      item.out_byte  = b;
      item.last_byte = 1'b0;
      seq = {seq, item};
    endfunction

    // seven bits per byte, low group first, bit 7 marks continuation
    function void push_varint(ref pef_pkg::out_item_t seq[$], input logic [63:0] v);
      while (v >= 64'h80) begin
        push_byte(seq, {1'b1, v[6:0]});
        v = v >> 7;
      end
      push_byte(seq, v[7:0]);
    endfunction

    function void note_request(pef_pkg::in_item_t r);
      pef_pkg::out_item_t seq[$];
      logic [63:0]        tag_varint;
      logic [63:0]        tag_len;
      logic [63:0]        tag_fixed;
      tag_varint = {32'b0, r.field_number, pef_pkg::WIRE_VARINT};
      tag_fixed  = {32'b0, r.field_number, pef_pkg::WIRE_FIXED64};
      tag_len    = {32'b0, r.field_number, pef_pkg::WIRE_LEN};
      case (r.req_type)
        pef_pkg::KIND_VARINT64: begin
          push_varint(seq, tag_varint);
          push_varint(seq, r.value);
        end
        pef_pkg::KIND_INT32: begin
          push_varint(seq, tag_varint);
          push_varint(seq, {{32{r.value[31]}}, r.value[31:0]});
        end
        pef_pkg::KIND_BOOL: begin
          push_varint(seq, tag_varint);
          push_byte(seq, (r.value != 64'd0) ? 8'd1 : 8'd0);
        end
        pef_pkg::KIND_FIXED64: begin
          push_varint(seq, tag_fixed);
          for (int i = 0; i < 8; i++) push_byte(seq, r.value[8*i +: 8]);
        end
        pef_pkg::KIND_LEN: begin
          push_varint(seq, tag_len);
          push_varint(seq, r.value);
        end
        pef_pkg::KIND_PAYLOAD: begin
          push_byte(seq, r.value[7:0]);
        end
        default: begin
        end
      endcase
      if (seq.size() == 0) return;
      seq[seq.size() - 1].last_byte = 1'b1;
      expected_bytes = {expected_bytes, seq};
    endfunction

    function void check_beat(pef_pkg::out_item_t got);
      pef_pkg::out_item_t want;
      beats_checked++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("beat %0d: byte %02h last %0b with nothing pending",
                         beats_checked, got.out_byte, got.last_byte));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("beat %0d: out_byte expected %02h got %02h",
                         beats_checked, want.out_byte, got.out_byte));
      if (got.last_byte !== want.last_byte)
        report($sformatf("beat %0d: last_byte expected %0b got %0b",
                         beats_checked, want.last_byte, got.last_byte));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  pef_pkg::in_item_t  in_data;
  logic               out_valid;
  pef_pkg::out_item_t out_data;

  wire_byte_board board;
  int             kind_count[8];
  int             idle_cycles;

  protobuf_field_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_beat(out_data);
  end

  // watchdog: a long stretch with no beat on either side means a hang
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called just after a rising edge; returns just after the accepting edge
  task automatic send_request(input pef_pkg::in_item_t r, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    board.note_request(r);
    kind_count[r.req_type]++;
  endtask

  task automatic send_fields(input logic [2:0] kind, input logic [28:0] field,
                             input logic [63:0] value, input int gap);
    pef_pkg::in_item_t r;
    r.req_type     = kind;
    r.field_number = field;
    r.value        = value;
    send_request(r, gap);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    // spread varint lengths over one to ten bytes
    return v >> $urandom_range(0, 63);
  endfunction

  function automatic logic [2:0] random_kind();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    return 3'($urandom_range(0, 5));
  endfunction

  initial begin
    int no_idle;
    int gap;
    board   = new();
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field and value extremes, every kind, the ignored kinds
    send_fields(pef_pkg::KIND_VARINT64, 29'd0,         64'd0,                   0);
    send_fields(pef_pkg::KIND_VARINT64, 29'd1,         64'd127,                 0);
    send_fields(pef_pkg::KIND_VARINT64, 29'd15,        64'd128,                 3);
    send_fields(pef_pkg::KIND_VARINT64, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_fields(pef_pkg::KIND_VARINT64, 29'd16,        64'h8000_0000_0000_0000, 0);
    send_fields(pef_pkg::KIND_INT32,    29'd2,         64'h0000_0000_8000_0000, 1);
    send_fields(pef_pkg::KIND_INT32,    29'd3,         64'hFFFF_FFFF_7FFF_FFFF, 0);
    send_fields(pef_pkg::KIND_INT32,    29'd4,         64'hDEAD_BEEF_FFFF_FFFF, 0);
    send_fields(pef_pkg::KIND_INT32,    29'h1FFF_FFFF, 64'hFFFF_FFFF_0000_0000, 2);
    send_fields(pef_pkg::KIND_BOOL,     29'd5,         64'd0,                   0);
    send_fields(pef_pkg::KIND_BOOL,     29'd6,         64'h8000_0000_0000_0000, 0);
    send_fields(pef_pkg::KIND_BOOL,     29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5);
    send_fields(pef_pkg::KIND_FIXED64,  29'd7,         64'h0123_4567_89AB_CDEF, 0);
    send_fields(pef_pkg::KIND_FIXED64,  29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_fields(pef_pkg::KIND_FIXED64,  29'd0,         64'd0,                   4);
    send_fields(pef_pkg::KIND_LEN,      29'd8,         64'd0,                   0);
    send_fields(pef_pkg::KIND_LEN,      29'd2047,      64'd300,                 0);
    send_fields(pef_pkg::KIND_LEN,      29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    send_fields(pef_pkg::KIND_PAYLOAD,  29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00, 0);
    send_fields(pef_pkg::KIND_PAYLOAD,  29'd0,         64'h0000_0000_0000_00FF, 0);
    send_fields(KIND_SPARE_A,           29'd9,         64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_fields(pef_pkg::KIND_VARINT64, 29'd10,        64'd1,                   0);
    send_fields(KIND_SPARE_B,           29'h1FFF_FFFF, 64'd0,                   2);
    send_fields(pef_pkg::KIND_PAYLOAD,  29'd11,        64'h55,                  0);

    // random requests; every 32 requests pick whether the sender idles at all
    no_idle = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
      gap = no_idle ? 0 : $urandom_range(0, 18);
      send_fields(random_kind(),
                  29'($urandom) & ((29'd1 << $urandom_range(0, 29)) - 29'd1),
                  random_value(), gap);
    end
    start <= 1'b0;

    while (board.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests per kind: varint64 %0d int32 %0d bool %0d fixed64 %0d",
             kind_count[pef_pkg::KIND_VARINT64], kind_count[pef_pkg::KIND_INT32],
             kind_count[pef_pkg::KIND_BOOL], kind_count[pef_pkg::KIND_FIXED64]);
    $display("  length %0d payload %0d ignored %0d; %0d wire bytes checked",
             kind_count[pef_pkg::KIND_LEN], kind_count[pef_pkg::KIND_PAYLOAD],
             kind_count[KIND_SPARE_A] + kind_count[KIND_SPARE_B],
             board.beats_checked);
    if (board.mismatches > 10)
      $display("%0d mismatches in all", board.mismatches);
    if (board.mismatches == 0 && board.expected_bytes.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (board.expected_bytes.size() != 0)
        $display("%0d expected bytes never arrived", board.expected_bytes.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
